// ===== design/quaternion_vector_rotate_unit_defines.svh =====
// Assertion macros for the quaternion rotation unit.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define QVR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qvr assertion failed");
`define QVR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("qvr assertion failed");
`else
`define QVR_ASSERT(lbl, prop)
`define QVR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== design/qvr_pkg.sv =====
package qvr_pkg;

  localparam int unsigned QW     = 16;
  localparam int unsigned VW     = 24;
  localparam int unsigned PW     = 40;
  localparam int unsigned NW     = 33;
  localparam int unsigned DW     = 41;
  localparam int unsigned MW     = 57;
  localparam int unsigned RW     = 60;
  localparam int unsigned QBITS  = VW;
  localparam int unsigned LAT    = 31;

  localparam logic [VW-1:0] VMAX_U = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN_U = {1'b1, {(VW-1){1'b0}}};

  typedef logic signed [QW-1:0] quat_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [DW-1:0] dot_t;
  typedef logic signed [MW-1:0] mul_t;
  typedef logic [RW-1:0]        rem_t;
  typedef logic [QBITS-1:0]     quo_t;

endpackage

// ===== design/quaternion_vector_rotate_unit.sv =====
// Quaternion vector rotation: rot = q * v * conj(q) / |q|^2, fixed point.
// Input: quat_* (Q2.14) and vec_* (Q16.8) are taken at a rising clock edge
// where start is high and busy is low. busy is always low: the block is a
// fully pipelined datapath and takes one item on every clock cycle.
// Output: done_o is high for exactly one cycle with rot_*, zero_quat_o and
// saturated_o valid in that cycle. Throughput is one item per cycle. An
// item passes through six arithmetic stages (products, sums, second
// products, numerator, rounding offset, overflow check), 24 stages of a
// restoring divider that yields one quotient bit per stage in each of the
// three lanes, and the output register.
// A zero quaternion returns a zero vector with zero_quat_o set; results
// are rounded to nearest (ties away from zero) and clamped to 24 bits with
// saturated_o set on a clamp.
// Reset clears all valid bits; items in flight are dropped. The receiver
// cannot stall, so the pipeline never holds.
`include "quaternion_vector_rotate_unit_defines.svh"

module quaternion_vector_rotate_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  qvr_pkg::quat_t        quat_x_i,
  input  qvr_pkg::quat_t        quat_y_i,
  input  qvr_pkg::quat_t        quat_z_i,
  input  qvr_pkg::quat_t        quat_w_i,
  input  qvr_pkg::vec_t         vec_x_i,
  input  qvr_pkg::vec_t         vec_y_i,
  input  qvr_pkg::vec_t         vec_z_i,
  output logic                  done_o,
  output qvr_pkg::vec_t         rot_x_o,
  output qvr_pkg::vec_t         rot_y_o,
  output qvr_pkg::vec_t         rot_z_o,
  output logic                  zero_quat_o,
  output logic                  saturated_o
);
  import qvr_pkg::*;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 0: products
  logic                     s0_vld_q;
  logic signed [2*QW-1:0]   s0_sq_q [4];
  prod_t                    s0_dp_q [3];
  prod_t                    s0_cp_q [6];
  quat_t                    s0_u_q  [3];
  quat_t                    s0_w_q;
  vec_t                     s0_v_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else         s0_vld_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    s0_sq_q[0] <= (2*QW)'(quat_x_i) * (2*QW)'(quat_x_i);
    s0_sq_q[1] <= (2*QW)'(quat_y_i) * (2*QW)'(quat_y_i);
    s0_sq_q[2] <= (2*QW)'(quat_z_i) * (2*QW)'(quat_z_i);
    s0_sq_q[3] <= (2*QW)'(quat_w_i) * (2*QW)'(quat_w_i);
    s0_dp_q[0] <= PW'(quat_x_i) * PW'(vec_x_i);
    s0_dp_q[1] <= PW'(quat_y_i) * PW'(vec_y_i);
    s0_dp_q[2] <= PW'(quat_z_i) * PW'(vec_z_i);
    s0_cp_q[0] <= PW'(quat_y_i) * PW'(vec_z_i);
    s0_cp_q[1] <= PW'(quat_z_i) * PW'(vec_y_i);
    s0_cp_q[2] <= PW'(quat_z_i) * PW'(vec_x_i);
    s0_cp_q[3] <= PW'(quat_x_i) * PW'(vec_z_i);
    s0_cp_q[4] <= PW'(quat_x_i) * PW'(vec_y_i);
    s0_cp_q[5] <= PW'(quat_y_i) * PW'(vec_x_i);
    s0_u_q[0]  <= quat_x_i;
    s0_u_q[1]  <= quat_y_i;
    s0_u_q[2]  <= quat_z_i;
    s0_w_q     <= quat_w_i;
    s0_v_q[0]  <= vec_x_i;
    s0_v_q[1]  <= vec_y_i;
    s0_v_q[2]  <= vec_z_i;
  end

  // stage 1: norm, scalar term, dot and cross
  logic                  s1_vld_q;
  logic [NW-1:0]         s1_n_q;
  logic signed [NW-1:0]  s1_s_q;
  dot_t                  s1_d_q;
  dot_t                  s1_c_q [3];
  quat_t                 s1_u_q [3];
  quat_t                 s1_w_q;
  vec_t                  s1_v_q [3];
  logic signed [NW-1:0]  s1_uu;

  assign s1_uu = NW'(s0_sq_q[0]) + NW'(s0_sq_q[1]) + NW'(s0_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= s0_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s1_n_q    <= NW'(s1_uu + NW'(s0_sq_q[3]));
    s1_s_q    <= NW'(s0_sq_q[3]) - s1_uu;
    s1_d_q    <= DW'(s0_dp_q[0]) + DW'(s0_dp_q[1]) + DW'(s0_dp_q[2]);
    s1_c_q[0] <= DW'(s0_cp_q[0]) - DW'(s0_cp_q[1]);
    s1_c_q[1] <= DW'(s0_cp_q[2]) - DW'(s0_cp_q[3]);
    s1_c_q[2] <= DW'(s0_cp_q[4]) - DW'(s0_cp_q[5]);
    s1_u_q    <= s0_u_q;
    s1_w_q    <= s0_w_q;
    s1_v_q    <= s0_v_q;
  end

  // stage 2: second products
  logic          s2_vld_q;
  logic [NW-1:0] s2_n_q;
  mul_t          s2_ps_q [3];
  mul_t          s2_pd_q [3];
  mul_t          s2_pw_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s2_n_q <= s1_n_q;
    for (int i = 0; i < 3; i++) begin
      s2_ps_q[i] <= MW'(s1_s_q) * MW'(s1_v_q[i]);
      s2_pd_q[i] <= MW'(s1_d_q) * MW'(s1_u_q[i]);
      s2_pw_q[i] <= MW'(s1_w_q) * MW'(s1_c_q[i]);
    end
  end

  // stage 3: numerator
  logic               s3_vld_q;
  logic [NW-1:0]      s3_n_q;
  logic signed [RW-1:0] s3_num_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else         s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s3_n_q <= s2_n_q;
    for (int i = 0; i < 3; i++) begin
      s3_num_q[i] <= RW'(s2_ps_q[i]) + (RW'(s2_pd_q[i]) <<< 1) + (RW'(s2_pw_q[i]) <<< 1);
    end
  end

  // stage 4: magnitude plus half divisor
  logic          s4_vld_q;
  logic [NW-1:0] s4_n_q;
  logic          s4_neg_q [3];
  rem_t          s4_dvd_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else         s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s4_n_q <= s3_n_q;
    for (int i = 0; i < 3; i++) begin
      s4_neg_q[i] <= s3_num_q[i][RW-1];
      s4_dvd_q[i] <= (s3_num_q[i][RW-1] ? rem_t'(-s3_num_q[i]) : rem_t'(s3_num_q[i]))
                     + rem_t'(s3_n_q >> 1);
    end
  end

  // stage 5: quotient overflow check, feeds divider
  logic          dv_vld_q [QBITS+1];
  logic [NW-1:0] dv_n_q   [QBITS+1];
  logic          dv_zero_q[QBITS+1];
  logic          dv_neg_q [QBITS+1][3];
  logic          dv_ovf_q [QBITS+1][3];
  rem_t          dv_rem_q [QBITS+1][3];
  quo_t          dv_quo_q [QBITS+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_vld_q[0] <= 1'b0;
    else         dv_vld_q[0] <= s4_vld_q;
  end

  always_ff @(posedge clk_i) begin
    dv_n_q[0]    <= s4_n_q;
    dv_zero_q[0] <= (s4_n_q == '0);
    for (int i = 0; i < 3; i++) begin
      dv_neg_q[0][i] <= s4_neg_q[i];
      dv_ovf_q[0][i] <= s4_dvd_q[i] >= (rem_t'(s4_n_q) << QBITS);
      dv_rem_q[0][i] <= s4_dvd_q[i];
      dv_quo_q[0][i] <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int unsigned K = QBITS - 1 - j;
    rem_t sh;
    assign sh = rem_t'(dv_n_q[j]) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[j+1] <= 1'b0;
      else         dv_vld_q[j+1] <= dv_vld_q[j];
    end

    always_ff @(posedge clk_i) begin
      dv_n_q[j+1]    <= dv_n_q[j];
      dv_zero_q[j+1] <= dv_zero_q[j];
      for (int i = 0; i < 3; i++) begin
        dv_neg_q[j+1][i] <= dv_neg_q[j][i];
        dv_ovf_q[j+1][i] <= dv_ovf_q[j][i];
        if (dv_rem_q[j][i] >= sh) begin
          dv_rem_q[j+1][i] <= dv_rem_q[j][i] - sh;
          dv_quo_q[j+1][i] <= dv_quo_q[j][i] | (quo_t'(1) << K);
        end else begin
          dv_rem_q[j+1][i] <= dv_rem_q[j][i];
          dv_quo_q[j+1][i] <= dv_quo_q[j][i];
        end
      end
    end
  end

  // output stage: sign, clamp, zero quaternion
  logic  out_vld_q;
  vec_t  out_rot_q [3];
  logic  out_zero_q;
  logic  out_sat_q;
  vec_t  rot_d [3];
  logic  clamp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_neg_q[QBITS][i]) begin
        clamp[i] = dv_ovf_q[QBITS][i] || (dv_quo_q[QBITS][i] > VMIN_U);
        rot_d[i] = clamp[i] ? vec_t'(VMIN_U) : vec_t'(-dv_quo_q[QBITS][i]);
      end else begin
        clamp[i] = dv_ovf_q[QBITS][i] || (dv_quo_q[QBITS][i] > VMAX_U);
        rot_d[i] = clamp[i] ? vec_t'(VMAX_U) : vec_t'(dv_quo_q[QBITS][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= dv_vld_q[QBITS];
  end

  always_ff @(posedge clk_i) begin
    out_zero_q <= dv_zero_q[QBITS];
    out_sat_q  <= !dv_zero_q[QBITS] && (clamp[0] || clamp[1] || clamp[2]);
    for (int i = 0; i < 3; i++) begin
      out_rot_q[i] <= dv_zero_q[QBITS] ? '0 : rot_d[i];
    end
  end

  assign done_o      = out_vld_q;
  assign rot_x_o     = out_rot_q[0];
  assign rot_y_o     = out_rot_q[1];
  assign rot_z_o     = out_rot_q[2];
  assign zero_quat_o = out_zero_q;
  assign saturated_o = out_sat_q;

  `QVR_ASSERT(a_latency, done_o == $past(accept, LAT))
  `QVR_ASSERT(a_zero_clean, done_o && zero_quat_o |-> !saturated_o && {rot_x_o, rot_y_o, rot_z_o} == '0)
  `QVR_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule
